// ===== design/tmcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmcs_pkg
// types, constants and constant functions shared by the colour restoration
// ----------------------------------------------------------------------------
package tmcs_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned SAT_W       = 17;
    localparam int unsigned FRAC_BITS   = 16;
    localparam int unsigned DIV_W       = 48;
    localparam int unsigned LANES       = 3;

    localparam logic [DATA_W-1:0] LUMA_FLOOR  = 32'd7;
    localparam logic [SAT_W-1:0]  SAT_RESET   = 17'd52429;
    localparam logic [SAT_W-1:0]  SAT_ONE     = 17'd65536;
    localparam logic [SAT_W-1:0]  SAT_MIN     = 17'd1;

    // lane depth: divider, leading one, normalise, squarings, power, exp, multiply, saturate
    localparam int unsigned LANE_LAT = DIV_W + 1 + 1 + FRAC_BITS + 1 + FRAC_BITS + 1 + 1;

    typedef struct packed {
        logic signed [DATA_W-1:0] red_in;
        logic signed [DATA_W-1:0] green_in;
        logic signed [DATA_W-1:0] blue_in;
        logic [DATA_W-1:0]        luma_original;
        logic [DATA_W-1:0]        luma_mapped;
    } pix_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] red_out;
        logic [DATA_W-1:0] green_out;
        logic [DATA_W-1:0] blue_out;
    } pix_out_t;

    // floor square root of a 64-bit value, elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        res  = '0;
        rem  = v;
        bitv = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (bitv != 0) begin
                if (rem >= res + bitv) begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // factor 2^(2^-(idx+1)) in q1.30, as the chain of floor roots from 2.0
    function automatic logic [31:0] fac_q30(input int idx);
        logic [63:0] f;
        f = 64'd1 << 31;
        for (int j = 0; j <= idx; j++) begin
            f = isqrt64(f << 30);
        end
        return f[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/tmcs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmcs interfaces
// valid/ready channels for pixel items and the saturation register write
// ----------------------------------------------------------------------------
interface tmcs_pix_in_if;
    import tmcs_pkg::*;
    logic    valid;
    logic    ready;
    pix_in_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tmcs_pix_out_if;
    import tmcs_pkg::*;
    logic     valid;
    logic     ready;
    pix_out_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tmcs_cfg_if;
    import tmcs_pkg::*;
    logic             valid;
    logic             ready;
    logic [SAT_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/tmcs_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmcs_lane
// one colour channel: ratio, log2, power, exp2, scale by mapped luminance
// ----------------------------------------------------------------------------
module tmcs_lane (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic [tmcs_pkg::DATA_W-1:0]    raw,
    input  wire logic [tmcs_pkg::DATA_W-1:0]    luma_y,
    input  wire logic [tmcs_pkg::DATA_W-1:0]    luma_l,
    input  wire logic [tmcs_pkg::SAT_W-1:0]     sat,
    output logic      [tmcs_pkg::DATA_W-1:0]    result
);
    import tmcs_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DIV_W-1:0]  work;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] l;
        logic [SAT_W-1:0]  s;
        logic              zero;
    } div_t;

    typedef struct packed {
        logic [DIV_W-1:0]  r;
        logic [5:0]        k;
        logic [DATA_W-1:0] l;
        logic [SAT_W-1:0]  s;
        logic              zero;
    } nrm_t;

    typedef struct packed {
        logic [30:0]          m;
        logic [FRAC_BITS-1:0] frac;
        logic [5:0]           k;
        logic [DATA_W-1:0]    l;
        logic [SAT_W-1:0]     s;
        logic                 zero;
    } log_t;

    typedef struct packed {
        logic [31:0]          m;
        logic [FRAC_BITS-1:0] f;
        logic [7:0]           pint;
        logic [DATA_W-1:0]    l;
        logic                 zero;
    } exp_t;

    typedef struct packed {
        logic [63:0] prod;
        logic [7:0]  pint;
        logic        zero;
    } mul_t;

    // one restoring division step: shift in a dividend bit, shift out a quotient bit
    function automatic div_t div_step(input div_t d);
        div_t        o;
        logic [32:0] t;
        o = d;
        t = {d.rem, d.work[DIV_W-1]};
        if (t >= {1'b0, d.y}) begin
            o.rem  = 32'(t - {1'b0, d.y});
            o.work = {d.work[DIV_W-2:0], 1'b1};
        end
        else begin
            o.rem  = t[31:0];
            o.work = {d.work[DIV_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // ---- divider ----
    div_t div_in;
    div_t div_reg [DIV_W];

    assign div_in.rem  = '0;
    assign div_in.work = {raw, 16'b0};
    assign div_in.y    = luma_y;
    assign div_in.l    = luma_l;
    assign div_in.s    = sat;
    assign div_in.zero = raw[DATA_W-1] || (raw == '0);

    for (genvar i = 0; i < DIV_W; i++) begin : g_div
        div_t div_next;
        if (i == 0) begin : g_first
            assign div_next = div_step(div_in);
        end
        else begin : g_rest
            assign div_next = div_step(div_reg[i-1]);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[i] <= div_next;
            end
        end
    end

    // ---- leading one ----
    nrm_t nrm_reg;
    nrm_t nrm_next;
    always_comb
    begin
        nrm_next.r    = div_reg[DIV_W-1].work;
        nrm_next.l    = div_reg[DIV_W-1].l;
        nrm_next.s    = div_reg[DIV_W-1].s;
        nrm_next.zero = div_reg[DIV_W-1].zero || (div_reg[DIV_W-1].work == '0);
        nrm_next.k    = '0;
        for (int j = 0; j < DIV_W; j++) begin
            if (div_reg[DIV_W-1].work[j])
            begin
                nrm_next.k = 6'(j);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nrm_reg <= nrm_next;
        end
    end

    // ---- normalise mantissa to q1.30 ----
    log_t log_reg [FRAC_BITS+1];
    log_t log_next0;
    logic [DIV_W-1:0] nrm_shifted;
    always_comb
    begin
        if (nrm_reg.k >= 6'd30)
        begin
            nrm_shifted = nrm_reg.r >> (nrm_reg.k - 6'd30);
        end
        else begin
            nrm_shifted = nrm_reg.r << (6'd30 - nrm_reg.k);
        end
        log_next0.m    = nrm_shifted[30:0];
        log_next0.frac = '0;
        log_next0.k    = nrm_reg.k;
        log_next0.l    = nrm_reg.l;
        log_next0.s    = nrm_reg.s;
        log_next0.zero = nrm_reg.zero;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            log_reg[0] <= log_next0;
        end
    end

    // ---- log2 fraction bits by repeated squaring, one bit a stage ----
    for (genvar i = 0; i < FRAC_BITS; i++) begin : g_sq
        log_t        sq_next;
        logic [61:0] sq;
        always_comb
        begin
            sq      = {31'b0, log_reg[i].m} * {31'b0, log_reg[i].m};
            sq_next = log_reg[i];
            if (sq[61])
            begin
                sq_next.m                   = sq[61:31];
                sq_next.frac[FRAC_BITS-1-i] = 1'b1;
            end
            else begin
                sq_next.m = sq[60:30];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                log_reg[i+1] <= sq_next;
            end
        end
    end

    // ---- power: log times exponent, plus bias ----
    exp_t        exp_reg [FRAC_BITS+1];
    exp_t        exp_next0;
    logic [38:0] pw_prod;
    logic [23:0] pw_sum;
    logic [16:0] pw_comp;
    always_comb
    begin
        pw_prod   = {17'b0, log_reg[FRAC_BITS].k, log_reg[FRAC_BITS].frac}
                  * {22'b0, log_reg[FRAC_BITS].s};
        pw_comp   = SAT_ONE - log_reg[FRAC_BITS].s;
        pw_sum    = 24'(pw_prod[38:16]) + 24'({pw_comp, 4'b0});
        exp_next0.m    = 32'd1 << 30;
        exp_next0.f    = pw_sum[15:0];
        exp_next0.pint = pw_sum[23:16];
        exp_next0.l    = log_reg[FRAC_BITS].l;
        exp_next0.zero = log_reg[FRAC_BITS].zero;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            exp_reg[0] <= exp_next0;
        end
    end

    // ---- 2^frac as a product of root factors, one factor a stage ----
    for (genvar i = 0; i < FRAC_BITS; i++) begin : g_exp
        localparam logic [31:0] FAC = fac_q30(i);
        exp_t        ex_next;
        logic [63:0] ex_prod;
        always_comb
        begin
            ex_prod = {32'b0, exp_reg[i].m} * {32'b0, FAC};
            ex_next = exp_reg[i];
            if (exp_reg[i].f[FRAC_BITS-1-i])
            begin
                ex_next.m = ex_prod[61:30];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                exp_reg[i+1] <= ex_next;
            end
        end
    end

    // ---- scale by mapped luminance ----
    mul_t mul_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_reg.prod <= {32'b0, exp_reg[FRAC_BITS].m} * {32'b0, exp_reg[FRAC_BITS].l};
            mul_reg.pint <= exp_reg[FRAC_BITS].pint;
            mul_reg.zero <= exp_reg[FRAC_BITS].zero;
        end
    end

    // ---- integer shift and saturate ----
    logic signed [9:0] sh;
    logic [9:0]        left;
    logic [63:0]       rshift;
    logic [95:0]       lshift;
    logic [31:0]       res_next;
    logic [31:0]       res_reg;
    always_comb
    begin
        sh       = 10'sd46 - $signed({2'b0, mul_reg.pint});
        left     = 10'(-sh);
        rshift   = mul_reg.prod >> sh[5:0];
        lshift   = {32'b0, mul_reg.prod} << left[4:0];
        res_next = '0;
        if (mul_reg.zero)
        begin
            res_next = '0;
        end
        else if (!sh[9])
        begin
            res_next = (rshift[63:32] != '0) ? '1 : rshift[31:0];
        end
        else if (mul_reg.prod == '0)
        begin
            res_next = '0;
        end
        else if (left >= 10'd32)
        begin
            res_next = '1;
        end
        else begin
            res_next = (lshift[95:32] != '0) ? '1 : lshift[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

`default_nettype wire

// ===== design/tone_map_color_saturation.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tone_map_color_saturation
// colour restoration after luminance tone mapping, three channel lanes
// ----------------------------------------------------------------------------
// path: an accepted item runs through the input stage, the lane pipeline and the merge stage
// throughput: one item per cycle; the whole pipeline advances together and
//   only holds while the output register is full and not taken
// reset: control state cleared, saturation register back to 0.8 (52429),
//   pipeline empty; data registers are not reset
module tone_map_color_saturation (
    input  wire logic          clk,
    input  wire logic          rst_n,
    tmcs_pix_in_if.sink        pix_in,
    tmcs_pix_out_if.source     pix_out,
    tmcs_cfg_if.sink           cfg
);
    import tmcs_pkg::*;

    localparam int unsigned TOTAL_LAT = LANE_LAT + 2;

    // saturation exponent register, always ready for a write
    logic [SAT_W-1:0] saturation_reg;
    logic [SAT_W-1:0] sat_clamped;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saturation_reg <= SAT_RESET;
        end
        else if (cfg.valid)
        begin
            saturation_reg <= cfg.data;
        end
    end

    // exponent of zero acts as the smallest step, anything above one as one
    always_comb
    begin
        if (saturation_reg < SAT_MIN)
        begin
            sat_clamped = SAT_MIN;
        end
        else if (saturation_reg > SAT_ONE)
        begin
            sat_clamped = SAT_ONE;
        end
        else begin
            sat_clamped = saturation_reg;
        end
    end

    // pipeline advances whenever the output register is empty or being taken
    logic advance;
    logic vld_reg [TOTAL_LAT];

    assign advance      = !vld_reg[TOTAL_LAT-1] || pix_out.ready;
    assign pix_in.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL_LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= pix_in.valid;
            for (int i = 1; i < TOTAL_LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // input stage: luminance floor and register snapshot
    logic [DATA_W-1:0] chan_reg [LANES];
    logic [DATA_W-1:0] y_reg;
    logic [DATA_W-1:0] l_reg;
    logic [SAT_W-1:0]  s_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            chan_reg[0] <= pix_in.data.red_in;
            chan_reg[1] <= pix_in.data.green_in;
            chan_reg[2] <= pix_in.data.blue_in;
            y_reg <= (pix_in.data.luma_original < LUMA_FLOOR) ? LUMA_FLOOR
                                                              : pix_in.data.luma_original;
            l_reg <= (pix_in.data.luma_mapped < LUMA_FLOOR) ? LUMA_FLOOR
                                                            : pix_in.data.luma_mapped;
            s_reg <= sat_clamped;
        end
    end

    // one lane per colour channel, all sharing luminance and exponent
    logic [DATA_W-1:0] lane_res [LANES];

    for (genvar c = 0; c < LANES; c++) begin : g_lane
        tmcs_lane u_lane (
            .clk    (clk),
            .en     (advance),
            .raw    (chan_reg[c]),
            .luma_y (y_reg),
            .luma_l (l_reg),
            .sat    (s_reg),
            .result (lane_res[c])
        );
    end

    // merge stage: the three lanes meet in the output register
    pix_out_t out_data_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg.red_out   <= lane_res[0];
            out_data_reg.green_out <= lane_res[1];
            out_data_reg.blue_out  <= lane_res[2];
        end
    end

    assign pix_out.valid = vld_reg[TOTAL_LAT-1];
    assign pix_out.data  = out_data_reg;

endmodule

`default_nettype wire

// ===== design/tmcs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmcs_checker
// port level checks on the colour restoration block
// ----------------------------------------------------------------------------
module tmcs_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_ready,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire tmcs_pkg::pix_out_t         out_data,
    input  wire logic                       cfg_valid,
    input  wire logic                       cfg_ready
);
    import tmcs_pkg::*;

    // stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // input taken exactly when the output slot frees up
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    // a new result only appears after the pipeline has moved
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_ready))
        else $error("result appeared while pipeline held");

    // register writes never back-pressure
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind tone_map_color_saturation tmcs_checker u_tmcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .out_data  (pix_out.data),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready)
);

`default_nettype wire
